@@ hw/rtl/card_whitelist_access_control_unit_macros.svh @@
// Assertion macros for the card whitelist access control unit.
// Depends on nothing; included by the top level.
`ifndef CARD_WHITELIST_ACCESS_CONTROL_UNIT_MACROS_SVH
`define CARD_WHITELIST_ACCESS_CONTROL_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CWAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cwac assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CWAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cwac assertion failed");

`endif

@@ hw/rtl/cwac_pkg.sv @@
// Shared constants, outcome codes and result type of the card whitelist unit.
// Depends on nothing.
package cwac_pkg;

	localparam int          NUM_SLOTS_DEF = 10;
	localparam int          ID_W          = 32;
	localparam logic [31:0] EMPTY_ID      = 32'hFFFF_FFFF;
	localparam logic [31:0] ADMIN_RESET   = 32'hF809_6656;

	localparam logic [2:0] OUT_ADMIN   = 3'd0;
	localparam logic [2:0] OUT_ADDED   = 3'd1;
	localparam logic [2:0] OUT_REMOVED = 3'd2;
	localparam logic [2:0] OUT_FULL    = 3'd3;
	localparam logic [2:0] OUT_GRANTED = 3'd4;
	localparam logic [2:0] OUT_DENIED  = 3'd5;

	typedef struct packed {
		logic [2:0] outcome;
		logic       locked;
		logic       admin_active;
	} cwac_res_t;

endpackage

@@ hw/rtl/card_whitelist_access_control_unit.sv @@
// Top level of the card whitelist access control unit: admin register, output word register.
// Depends on cwac_pkg, cwac_seq (which holds cwac_table) and the assertion macro header.
//
//   Channel  Handshake               Word
//   in       in_valid / in_stall     card_id[31:0]
//   out      out_valid / out_stall   outcome[2:0], locked, admin_active
//   cfg      cfg_wr_en               cfg_wr_data[31:0] (admin card identifier)
//
// A scan of the admin card goes from CHECK to DONE, and its result word is then loaded.
// Any other card walks the whole table in SCAN, then DECIDE and DONE: the
// table memory is read one slot per cycle into the shared 32-bit comparator.
// The next word can be accepted in the cycle after the result is loaded into the output register.
// Reset empties the table at once through per-slot valid bits; the lock is closed and
// admin mode is off. A stalled output word holds; the sequencer waits for the register.
`include "card_whitelist_access_control_unit_macros.svh"

module card_whitelist_access_control_unit
	import cwac_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [ID_W-1:0] cfg_wr_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [ID_W-1:0] card_id,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      outcome,
	output logic            locked,
	output logic            admin_active
);

	logic [ID_W-1:0] admin_id_q;
	logic            out_valid_q;
	cwac_res_t       out_word_q;
	cwac_res_t       res;
	logic            res_load;
	logic            res_ready;

	// The user must write the admin register only while the unit is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			admin_id_q <= ADMIN_RESET;
		end else if (cfg_wr_en) begin
			admin_id_q <= cfg_wr_data;
		end
	end

	// The output register is free when empty or when its word leaves this cycle.
	assign res_ready = !out_valid_q || !out_stall;

	cwac_seq #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.card_id  (card_id),
		.admin_id (admin_id_q),
		.res_ready(res_ready),
		.res_load (res_load),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_word_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign outcome      = out_word_q.outcome;
	assign locked       = out_word_q.locked;
	assign admin_active = out_word_q.admin_active;

	// An accepted word keeps the unit busy in the following cycle.
	`CWAC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// Entering admin mode always reports admin mode armed.
	`CWAC_ASSERT_NOW(a_admin_armed, clk, arst_n, out_valid && (outcome == OUT_ADMIN), admin_active)
	// Any table action ends admin mode.
	`CWAC_ASSERT_NOW(a_admin_ends, clk, arst_n,
		out_valid && (outcome == OUT_ADDED || outcome == OUT_REMOVED || outcome == OUT_FULL),
		!admin_active)
	// A result is never loaded over a stalled word still waiting at the output.
	`CWAC_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid && out_stall, !res_load)

endmodule

@@ hw/rtl/cwac_table.sv @@
// Identifier table: memory with one read and one write port, a registered read and per-slot valid bits.
// Depends on cwac_pkg. A slot never written reads as the empty marker.
module cwac_table
	import cwac_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [ID_W-1:0]   rd_data,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [ID_W-1:0]   wr_data
);

	logic [ID_W-1:0]      mem_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] slot_valid_q;
	logic [ID_W-1:0]      rd_word_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_word_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			rd_valid_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				slot_valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= slot_valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : EMPTY_ID;

endmodule

@@ hw/rtl/cwac_seq.sv @@
// Sequencer with the shared 32-bit compare unit, lock and admin flags.
// Depends on cwac_pkg and cwac_table.
module cwac_seq
	import cwac_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [ID_W-1:0] card_id,
	input  logic [ID_W-1:0] admin_id,
	input  logic            res_ready,
	output logic            res_load,
	output cwac_res_t       res
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CHECK  = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_DONE   = 5'b10000
	} cwac_state_t;

	cwac_state_t      state_q;
	logic [ID_W-1:0]  id_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             issued_all_q;
	logic             cmp_vld_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic             hit_found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             empty_found_q;
	logic [IDX_W-1:0] empty_idx_q;
	logic             lock_closed_q;
	logic             admin_armed_q;
	logic [2:0]       outcome_q;

	logic [ID_W-1:0]  rd_data;
	logic [ID_W-1:0]  cmp_b;
	logic             eq;
	logic             is_empty;
	logic             issuing;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [ID_W-1:0]  wr_data;

	// The shared compare unit: admin check in CHECK, table words during SCAN.
	assign cmp_b    = (state_q == ST_CHECK) ? admin_id : rd_data;
	assign eq       = (id_q == cmp_b);
	assign is_empty = (rd_data == EMPTY_ID);
	assign issuing  = (state_q == ST_SCAN) && !issued_all_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_data = EMPTY_ID;
		if ((state_q == ST_DECIDE) && admin_armed_q) begin
			if (hit_found_q) begin
				wr_en = 1'b1;
			end else if (empty_found_q) begin
				wr_en   = 1'b1;
				wr_addr = empty_idx_q;
				wr_data = id_q;
			end
		end
	end

	cwac_table #(
		.NUM_SLOTS(NUM_SLOTS),
		.IDX_W    (IDX_W)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(rd_idx_q),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			id_q <= card_id;
		end
		if (cmp_vld_q) begin
			if (!hit_found_q && eq) begin
				hit_idx_q <= cmp_idx_q;
			end
			if (!empty_found_q && is_empty) begin
				empty_idx_q <= cmp_idx_q;
			end
		end
		cmp_idx_q <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_idx_q      <= '0;
			issued_all_q  <= 1'b0;
			cmp_vld_q     <= 1'b0;
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
			lock_closed_q <= 1'b1;
			admin_armed_q <= 1'b0;
			outcome_q     <= OUT_DENIED;
		end else begin
			cmp_vld_q <= issuing;
			if (issuing) begin
				if (rd_idx_q == LAST_IDX) begin
					issued_all_q <= 1'b1;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			if (cmp_vld_q) begin
				if (eq) begin
					hit_found_q <= 1'b1;
				end
				if (is_empty) begin
					empty_found_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					rd_idx_q      <= '0;
					issued_all_q  <= 1'b0;
					hit_found_q   <= 1'b0;
					empty_found_q <= 1'b0;
					if (eq) begin
						admin_armed_q <= 1'b1;
						outcome_q     <= OUT_ADMIN;
						state_q       <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cmp_vld_q && (cmp_idx_q == LAST_IDX)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (admin_armed_q) begin
						admin_armed_q <= 1'b0;
						if (hit_found_q) begin
							outcome_q <= OUT_REMOVED;
						end else if (empty_found_q) begin
							outcome_q <= OUT_ADDED;
						end else begin
							outcome_q <= OUT_FULL;
						end
					end else if (hit_found_q) begin
						lock_closed_q <= !lock_closed_q;
						outcome_q     <= OUT_GRANTED;
					end else begin
						outcome_q <= OUT_DENIED;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign res_load         = (state_q == ST_DONE) && res_ready;
	assign res.outcome      = outcome_q;
	assign res.locked       = lock_closed_q;
	assign res.admin_active = admin_armed_q;

endmodule

@@ test/tb_card_whitelist_access_control_unit.sv @@
// Self-checking testbench for the card whitelist access control unit.
// Depends on cwac_pkg and card_whitelist_access_control_unit; reads no files.
`timescale 1ns / 1ps

module tb_card_whitelist_access_control_unit;
	import cwac_pkg::*;

	// The run is stopped by the watchdog below if it ever hangs. A correct run
	// needs far fewer cycles, even with the receiver stalling most of the time.
	localparam int CYCLE_LIMIT  = 1_000_000;
	// Extra cycles given to the block before a register write and at the end.
	// The slowest scan walks the whole table.
	localparam int DRAIN_CYCLES = NUM_SLOTS_DEF + 10;
	localparam int SHOWN_ERRORS = 10;

	// Each accepted card word leaves one expected result word behind. The
	// card identifier is kept with it so that a mismatch can be traced.
	typedef struct {
		cwac_res_t       res;
		logic [ID_W-1:0] id;
	} pending_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_wr_en;
	logic [ID_W-1:0] cfg_wr_data;
	logic            in_valid;
	logic            in_stall;
	logic [ID_W-1:0] card_id;
	logic            out_valid;
	logic            out_stall;
	logic [2:0]      outcome;
	logic            locked;
	logic            admin_active;

	// Our own copy of the unit's state: the admin register, the slot table,
	// the lock and the admin-mode flag.
	logic [ID_W-1:0] admin_id;
	logic [ID_W-1:0] slot_ids [NUM_SLOTS_DEF];
	logic            lock_shut;
	logic            admin_mode;

	pending_t pending_q [$];

	int sender_idle_pct;
	int recv_stall_pct;
	int items_sent;
	int words_checked;
	int fail_count;
	int admin_writes;
	int cycle_count;
	int outcome_seen [6];

	card_whitelist_access_control_unit #(
		.NUM_SLOTS(NUM_SLOTS_DEF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.card_id(card_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.outcome(outcome),
		.locked(locked),
		.admin_active(admin_active)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Index of the first slot holding id, or NUM_SLOTS_DEF when none does.
	// All 32 bits take part in the comparison.
	function automatic int first_slot_of(input logic [ID_W-1:0] id);
		for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
			if (slot_ids[i] == id) begin
				return i;
			end
		end
		return NUM_SLOTS_DEF;
	endfunction

	// Applies one scan to the local state and returns the word the unit
	// should produce for it. Note that an all-ones card matches an empty
	// slot, so it counts as enrolled as long as the table is not full.
	function automatic cwac_res_t predict_scan(input logic [ID_W-1:0] id);
		cwac_res_t r;
		int        hit;
		if (id == admin_id) begin
			// The admin card always arms admin mode, even when it is already armed.
			admin_mode = 1'b1;
			r.outcome  = OUT_ADMIN;
		end else if (admin_mode) begin
			hit = first_slot_of(id);
			if (hit < NUM_SLOTS_DEF) begin
				slot_ids[hit] = EMPTY_ID;
				r.outcome     = OUT_REMOVED;
			end else begin
				hit = first_slot_of(EMPTY_ID);
				if (hit < NUM_SLOTS_DEF) begin
					slot_ids[hit] = id;
					r.outcome     = OUT_ADDED;
				end else begin
					r.outcome = OUT_FULL;
				end
			end
			admin_mode = 1'b0;
		end else if (first_slot_of(id) < NUM_SLOTS_DEF) begin
			lock_shut = !lock_shut;
			r.outcome = OUT_GRANTED;
		end else begin
			r.outcome = OUT_DENIED;
		end
		r.locked       = lock_shut;
		r.admin_active = admin_mode;
		return r;
	endfunction

	// An enrolled card chosen at random, or a random identifier when the
	// table holds nothing.
	function automatic logic [ID_W-1:0] pick_enrolled_id();
		int start;
		int idx;
		start = $urandom_range(0, NUM_SLOTS_DEF - 1);
		for (int k = 0; k < NUM_SLOTS_DEF; k++) begin
			idx = (start + k) % NUM_SLOTS_DEF;
			if (slot_ids[idx] != EMPTY_ID) begin
				return slot_ids[idx];
			end
		end
		return $urandom;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= SHOWN_ERRORS) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endtask

	// Presents one card word and returns at the edge where it is taken. The
	// sender may first idle for a random number of cycles. While the unit
	// stalls, the word is held unchanged. Valid stays high from one word to
	// the next when no idle cycle falls between them.
	task automatic send_card(input logic [ID_W-1:0] id);
		pending_t p;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		card_id  <= id;
		do @(posedge clk); while (in_stall);
		p.id  = id;
		p.res = predict_scan(id);
		pending_q.push_back(p);
		items_sent++;
	endtask

	// Stops sending and waits until every expected word has come back. Then
	// it gives the unit a few extra cycles so that it is surely idle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The admin register is only written while the unit is idle.
	task automatic write_admin_id(input logic [ID_W-1:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		admin_id = value;
		admin_writes++;
	endtask

	// Enrollment, lock toggling and removal with the admin card from reset.
	// This also covers an admin scan while admin mode is already armed, and a
	// card that is denied after its removal.
	task automatic test_enroll_and_toggle();
		send_card(32'h0000_0000);
		send_card(ADMIN_RESET);
		send_card(ADMIN_RESET);
		send_card(32'h0000_0000);
		send_card(32'h0000_0000);
		send_card(32'h0000_0000);
		send_card(ADMIN_RESET);
		send_card(32'h0000_0000);
		send_card(32'h0000_0000);
	endtask

	// An all-ones card matches an empty slot. In normal mode it is granted,
	// and in admin mode it is removed, which leaves the table unchanged.
	task automatic test_all_ones_card();
		send_card(EMPTY_ID);
		send_card(ADMIN_RESET);
		send_card(EMPTY_ID);
	endtask

	// Moves the admin identifier to both extremes. The old admin card then
	// behaves like any other card and can be enrolled. An all-ones admin card
	// arms admin mode instead of matching empty slots.
	task automatic test_admin_register();
		write_admin_id(32'h0000_0000);
		send_card(ADMIN_RESET);
		send_card(32'h0000_0000);
		send_card(ADMIN_RESET);
		send_card(ADMIN_RESET);
		write_admin_id(32'hFFFF_FFFF);
		send_card(EMPTY_ID);
		send_card(EMPTY_ID);
		send_card(32'h0000_0000);
	endtask

	// Mostly well-formed scan sequences with random content: enroll a new card,
	// remove an enrolled one, or present an enrolled card to the lock. The rest
	// is noise: unknown cards, all-ones cards, lone admin scans and cards one
	// bit away from an enrolled card. Enrollment outweighs removal, so the
	// table fills up often and table-full results occur.
	task automatic test_random_scans(input int n, input int s_pct, input int r_pct,
		input logic [ID_W-1:0] admin);
		int stop_at;
		int pick;
		write_admin_id(admin);
		sender_idle_pct = s_pct;
		recv_stall_pct  = r_pct;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_card(admin_id);
				send_card($urandom);
			end else if (pick < 45) begin
				send_card(admin_id);
				send_card(pick_enrolled_id());
			end else if (pick < 70) begin
				send_card(pick_enrolled_id());
			end else if (pick < 82) begin
				send_card($urandom);
			end else if (pick < 88) begin
				send_card(EMPTY_ID);
			end else if (pick < 93) begin
				send_card(admin_id);
			end else begin
				send_card(pick_enrolled_id() ^ (32'd1 << $urandom_range(0, ID_W - 1)));
			end
		end
	endtask

	// The receiver stalls at random, with the chance set by the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Every result word that is taken is checked field by field against the
	// oldest expectation.
	always @(posedge clk) begin : check_results
		pending_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				note_failure($sformatf("unexpected result word: outcome %0d locked %0b admin %0b",
					outcome, locked, admin_active));
			end else begin
				want = pending_q.pop_front();
				words_checked++;
				if (outcome !== want.res.outcome || locked !== want.res.locked ||
					admin_active !== want.res.admin_active) begin
					note_failure($sformatf(
						"card %h: expected outcome %0d locked %0b admin %0b, got %0d %0b %0b",
						want.id, want.res.outcome, want.res.locked, want.res.admin_active,
						outcome, locked, admin_active));
				end else if (outcome < 6) begin
					outcome_seen[outcome]++;
				end
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding",
			cycle_count, pending_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		in_valid        = 1'b0;
		card_id         = '0;
		out_stall       = 1'b0;
		sender_idle_pct = 18;
		recv_stall_pct  = 83;
		items_sent      = 0;
		words_checked   = 0;
		fail_count      = 0;
		admin_writes    = 0;
		foreach (outcome_seen[i]) outcome_seen[i] = 0;

		// After reset the table is empty, the lock is closed, admin mode is
		// off and the admin register holds its default identifier.
		admin_id   = ADMIN_RESET;
		lock_shut  = 1'b1;
		admin_mode = 1'b0;
		foreach (slot_ids[i]) slot_ids[i] = EMPTY_ID;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_enroll_and_toggle();
		test_all_ones_card();
		test_admin_register();

		// Three random phases with different idling. First the receiver stalls
		// most of the time, then the sender idles most of the time, then
		// neither side idles.
		test_random_scans(510, 18, 83, $urandom);
		test_random_scans(510, 83, 18, ADMIN_RESET);
		test_random_scans(510, 0, 0, $urandom);
		wait_idle();

		$display("Checked %0d result words for %0d scans under %0d admin identifier writes.",
			words_checked, items_sent, admin_writes);
		$display("Outcomes: %0d admin, %0d added, %0d removed, %0d full, %0d granted, %0d denied.",
			outcome_seen[OUT_ADMIN], outcome_seen[OUT_ADDED], outcome_seen[OUT_REMOVED],
			outcome_seen[OUT_FULL], outcome_seen[OUT_GRANTED], outcome_seen[OUT_DENIED]);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches in total", fail_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/cwac_pkg.sv
hw/rtl/cwac_table.sv
hw/rtl/cwac_seq.sv
hw/rtl/card_whitelist_access_control_unit.sv
test/tb_card_whitelist_access_control_unit.sv
